@@ sv/mas_pkg.sv @@
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types, constants and helpers for the matrix add/subtract/multiply
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

  // Matrix dimension and derived sizes.
  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RC_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int VAL_W = 16;

  // Index of the last row and column, as carried on the result fields.
  localparam logic [2:0] LAST_RC = 3'(DIM - 1);

  // Operation register codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // Input mode codes.
  localparam logic [1:0] MODE_WR_A    = 2'd0;
  localparam logic [1:0] MODE_WR_B    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [2:0]              result_row;
    logic [2:0]              result_col;
    logic                    last;
  } out_item_t;

  // Commands handed from the front end to the execution engine.
  typedef enum logic [2:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_MUL    = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Row-major storage index of element (r, c).
  function automatic logic [IDX_W-1:0] cell_idx(input logic [RC_W-1:0] r,
                                                input logic [RC_W-1:0] c);
    return IDX_W'(int'(r) * DIM + int'(c));
  endfunction

endpackage

`default_nettype wire

@@ sv/matrix_add_sub_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply_unit
// Stores two DIM x DIM matrices of 16-bit elements and emits A+B, A-B or A*B.
// ----------------------------------------------------------------------------
// Load transactions write one element of A or B in the execution engine; a
// two-entry command queue lets up to two further loads or computes be
// queued while a compute runs. A compute transaction streams DIM*DIM
// results in row-major order, with last set on the final one: add and
// subtract form each result in a calc step, the product in a multiply and
// an accumulate step per inner term on the single shared multiply-accumulate
// unit, and the engine works on one result element at a time. Results
// wrap to 16 bits. Loads outside the matrix, mode 3 and a compute with
// operation 3 are taken and produce nothing. Write the operation register
// only while no compute is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_add_sub_multiply_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire mas_pkg::in_item_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      mas_pkg::out_item_t out_data_o
);

  logic [1:0]    operation_q;
  logic          q_full, q_empty, q_push, q_pop;
  mas_pkg::cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operation_q <= mas_pkg::OP_ADD;
    end else if (cfg_we_i) begin
      operation_q <= cfg_wdata_i;
    end
  end

  mas_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .operation_i (operation_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  mas_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  mas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/mas_front.sv @@
// ----------------------------------------------------------------------------
// mas_front
// Decodes incoming transactions into load or compute commands and drops
// those that have no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_front (
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire mas_pkg::in_item_t in_data_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic              q_full_i,
  output      logic              q_push_o,
  output      mas_pkg::cmd_t     q_cmd_o
);

  logic in_range;
  logic keep;

  assign in_range = ({1'b0, in_data_i.row} < 4'(mas_pkg::DIM)) &&
                    ({1'b0, in_data_i.col} < 4'(mas_pkg::DIM));

  always_comb begin
    keep            = 1'b0;
    q_cmd_o.kind    = mas_pkg::CMD_LOAD_A;
    q_cmd_o.idx     = mas_pkg::cell_idx(mas_pkg::RC_W'(in_data_i.row),
                                        mas_pkg::RC_W'(in_data_i.col));
    q_cmd_o.value   = in_data_i.value;
    case (in_data_i.mode)
      mas_pkg::MODE_WR_A: begin
        keep         = in_range;
        q_cmd_o.kind = mas_pkg::CMD_LOAD_A;
      end
      mas_pkg::MODE_WR_B: begin
        keep         = in_range;
        q_cmd_o.kind = mas_pkg::CMD_LOAD_B;
      end
      mas_pkg::MODE_COMPUTE: begin
        case (operation_i)
          mas_pkg::OP_ADD: begin
            keep         = 1'b1;
            q_cmd_o.kind = mas_pkg::CMD_ADD;
          end
          mas_pkg::OP_SUB: begin
            keep         = 1'b1;
            q_cmd_o.kind = mas_pkg::CMD_SUB;
          end
          mas_pkg::OP_MUL: begin
            keep         = 1'b1;
            q_cmd_o.kind = mas_pkg::CMD_MUL;
          end
          default: keep = 1'b0;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  // Transactions that do nothing are still taken, they just never reach
  // the queue.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

@@ sv/mas_queue.sv @@
// ----------------------------------------------------------------------------
// mas_queue
// Two-entry command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mas_pkg::cmd_t push_cmd_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      mas_pkg::cmd_t pop_cmd_o,
  output      logic          empty_o
);

  mas_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/mas_back.sv @@
// ----------------------------------------------------------------------------
// mas_back
// Execution engine: holds matrices A and B, applies loads and walks the
// result matrix for compute commands, one element at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire mas_pkg::cmd_t      q_cmd_i,
  output      logic               q_pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      mas_pkg::out_item_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  localparam logic [mas_pkg::RC_W-1:0] RC_LAST = mas_pkg::RC_W'(mas_pkg::DIM - 1);

  state_e                        state_q, state_d;
  logic [mas_pkg::VAL_W-1:0]     mat_a_q [mas_pkg::CELLS];
  logic [mas_pkg::VAL_W-1:0]     mat_b_q [mas_pkg::CELLS];
  logic [mas_pkg::RC_W-1:0]      r_q, r_d, c_q, c_d, k_q, k_d;
  logic                          is_mul_q, is_mul_d;
  logic                          is_sub_q, is_sub_d;
  logic [mas_pkg::VAL_W-1:0]     acc_q, acc_d;
  logic [mas_pkg::VAL_W-1:0]     prod_q, prod_d;
  logic [mas_pkg::VAL_W-1:0]     res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  mas_pkg::out_item_t            out_q, out_d;

  logic [mas_pkg::IDX_W-1:0]     a_idx, b_idx;
  logic [mas_pkg::VAL_W-1:0]     a_rd, b_rd;
  logic [2*mas_pkg::VAL_W-1:0]   prod_full;
  logic [mas_pkg::VAL_W-1:0]     acc_sum;
  logic                          elem_last;
  logic                          emit_go;

  // In the multiply the column of A and the row of B follow k.
  always_comb begin
    if (state_q == ST_MUL) begin
      a_idx = mas_pkg::cell_idx(r_q, k_q);
      b_idx = mas_pkg::cell_idx(k_q, c_q);
    end else begin
      a_idx = mas_pkg::cell_idx(r_q, c_q);
      b_idx = a_idx;
    end
  end

  assign a_rd      = mat_a_q[a_idx];
  assign b_rd      = mat_b_q[b_idx];
  // The low half of the product is the same for signed and unsigned operands.
  assign prod_full = a_rd * b_rd;
  assign acc_sum   = acc_q + prod_q;
  assign elem_last = (r_q == RC_LAST) && (c_q == RC_LAST);
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    is_mul_d    = is_mul_q;
    is_sub_d    = is_sub_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          r_d      = '0;
          c_d      = '0;
          k_d      = '0;
          acc_d    = '0;
          is_mul_d = (q_cmd_i.kind == mas_pkg::CMD_MUL);
          is_sub_d = (q_cmd_i.kind == mas_pkg::CMD_SUB);
          case (q_cmd_i.kind)
            mas_pkg::CMD_ADD, mas_pkg::CMD_SUB: state_d = ST_CALC;
            mas_pkg::CMD_MUL:                   state_d = ST_MUL;
            default:                            state_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        res_d   = is_sub_q ? (a_rd - b_rd) : (a_rd + b_rd);
        state_d = ST_EMIT;
      end
      ST_MUL: begin
        prod_d  = prod_full[mas_pkg::VAL_W-1:0];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (k_q == RC_LAST) begin
          res_d   = acc_sum;
          state_d = ST_EMIT;
        end else begin
          acc_d   = acc_sum;
          k_d     = k_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d         = 1'b1;
          out_d.result_value  = res_q;
          out_d.result_row    = 3'(r_q);
          out_d.result_col    = 3'(c_q);
          out_d.last          = elem_last;
          k_d                 = '0;
          acc_d               = '0;
          if (elem_last) begin
            state_d = ST_IDLE;
          end else begin
            if (c_q == RC_LAST) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
            state_d = is_mul_q ? ST_MUL : ST_CALC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      is_mul_q    <= 1'b0;
      is_sub_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      is_mul_q    <= is_mul_d;
      is_sub_q    <= is_sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Both matrices come out of reset as all zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mas_pkg::CELLS; i++) begin
        mat_a_q[i] <= '0;
        mat_b_q[i] <= '0;
      end
    end else if (q_pop_o) begin
      if (q_cmd_i.kind == mas_pkg::CMD_LOAD_A) begin
        mat_a_q[q_cmd_i.idx] <= q_cmd_i.value;
      end
      if (q_cmd_i.kind == mas_pkg::CMD_LOAD_B) begin
        mat_b_q[q_cmd_i.idx] <= q_cmd_i.value;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sv/mas_checker.sv @@
// ----------------------------------------------------------------------------
// mas_checker
// Port-level checks on the result stream of the matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire mas_pkg::out_item_t out_data_o
);

  // A result transaction stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Coordinates never leave the matrix.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_row <= mas_pkg::LAST_RC) &&
                    (out_data_o.result_col <= mas_pkg::LAST_RC))
    else $error("result coordinate outside the matrix");

  // Last marks exactly the bottom-right element.
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last ==
      ((out_data_o.result_row == mas_pkg::LAST_RC) &&
       (out_data_o.result_col == mas_pkg::LAST_RC)))
    else $error("last flag does not match the final element");

  // Results come in row-major order: after a non-final element is taken the
  // next one moves one column right or wraps to the next row.
  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last ##1 out_valid_o |->
      ((out_data_o.result_row == $past(out_data_o.result_row)) &&
       (out_data_o.result_col == $past(out_data_o.result_col) + 3'd1)) ||
      ((out_data_o.result_row == $past(out_data_o.result_row) + 3'd1) &&
       (out_data_o.result_col == 3'd0)))
    else $error("result elements out of row-major order");

endmodule

bind matrix_add_sub_multiply_unit mas_checker u_mas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
